@@ src/mstt_pkg.sv @@
// ============================================================================
// mstt_pkg: shared types and constants of the timer slot table
// Holds the operation codes, the field widths, the controller state type and
// the command and status groups between the controller and the datapath.
// ============================================================================
package mstt_pkg;

   // Field widths of the request, response and configuration ports.
   localparam int KIND_W     = 3;
   localparam int HANDLER_W  = 16;
   localparam int INTERVAL_W = 32;
   localparam int TICK_W     = 10;

   // Reset value of the tick length register.
   localparam logic [TICK_W-1:0] TICK_RESET = 10'd1;

   // One scan reports at most this many expired slots.
   localparam int MAX_OUT   = 16;
   localparam int OUT_CNT_W = 5;

   // Operation codes carried in the kind field.
   localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CHECK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TICK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SCAN   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_CLEAN  = 3'd5;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_RUN,
      ST_ADD_WRITE,
      ST_WALK,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // latch the request and start the divider
      logic search;      // look for the first free slot
      logic add_commit;  // write the new timer into the free slot
      logic walk;        // process one slot per cycle unless stalled
      logic clear_all;   // free every slot
      logic finish;      // load the closing response
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic search_done;
      logic walk_done;
      logic out_free;
   } status_type;

endpackage

@@ src/mstt_ram.sv @@
// ============================================================================
// mstt_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read data output.
// ============================================================================
module mstt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/mstt_div.sv @@
// ============================================================================
// mstt_div: iterative interval divider
// Restoring division of the interval by the tick length, one quotient bit
// per cycle.
// ============================================================================
module mstt_div
   import mstt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [INTERVAL_W-1:0] dividend,
   input  logic [TICK_W-1:0]     divisor,
   output logic                  done,
   output logic [INTERVAL_W-1:0] quotient
);

   localparam int ITER_W = $clog2(INTERVAL_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ITER_W-1:0]     iter_ff, iter_in;
   logic [INTERVAL_W-1:0] quo_ff, quo_in;
   logic [TICK_W-1:0]     rem_ff, rem_in;
   logic [TICK_W-1:0]     dvs_ff, dvs_in;
   logic [TICK_W:0]       shifted;
   logic [TICK_W:0]       diff;
   logic                  ge;

   // One restoring step: shift in the next dividend bit and try to subtract.
   always_comb begin
      shifted = {rem_ff, quo_ff[INTERVAL_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = (shifted >= {1'b0, dvs_ff});
   end

   // Next state of the iteration.
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      iter_in = iter_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         iter_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[INTERVAL_W-2:0], ge};
         rem_in  = ge ? diff[TICK_W-1:0] : shifted[TICK_W-1:0];
         iter_in = iter_ff + ITER_W'(1);
         if (iter_ff == ITER_W'(INTERVAL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers take reset; the operands do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ src/mstt_ctrl.sv @@
// ============================================================================
// mstt_ctrl: operation sequencer
// Accepts one request at a time and steps the datapath through the divide,
// search, slot walk and response phases of the operation.
// ============================================================================
module mstt_ctrl
   import mstt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [KIND_W-1:0] req_kind,
   input  status_type        status,
   output cmd_type           cmd
);

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (req_kind)
                  KIND_ADD: begin
                     state_in = ST_ADD_RUN;
                  end
                  KIND_CHECK, KIND_DELETE, KIND_TICK, KIND_SCAN: begin
                     state_in = ST_WALK;
                  end
                  KIND_CLEAN: begin
                     cmd.clear_all = 1'b1;
                     state_in      = ST_FINISH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_ADD_RUN: begin
            cmd.search = 1'b1;
            if (status.div_done && status.search_done) begin
               state_in = ST_ADD_WRITE;
            end
         end
         ST_ADD_WRITE: begin
            cmd.add_commit = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ src/mstt_dp.sv @@
// ============================================================================
// mstt_dp: slot table datapath
// Holds the slot RAM, the occupied bits, the divider, the tick length
// register and the response register; walks one slot per cycle unless stalled.
// ============================================================================
module mstt_dp
   import mstt_pkg::*;
#(
   parameter int SLOTS      = 16,
   parameter int COUNT_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [HANDLER_W-1:0]  req_handler_id,
   input  logic [INTERVAL_W-1:0] req_interval_ms,
   input  logic                  req_once_mode,
   input  logic                  csr_wr_en,
   input  logic [TICK_W-1:0]     csr_wr_data,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic                  rsp_ok,
   output logic                  rsp_fired,
   output logic [HANDLER_W-1:0]  rsp_fired_handler,
   output logic                  rsp_last
);

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int WORD_W = HANDLER_W + 2 * COUNT_BITS + 1;
   localparam logic [INTERVAL_W-1:0] COUNT_MAX =
      INTERVAL_W'((64'd1 << COUNT_BITS) - 64'd1);

   // Latched request and configuration.
   logic [KIND_W-1:0]    kind_ff;
   logic [HANDLER_W-1:0] handler_ff;
   logic                 once_ff;
   logic [TICK_W-1:0]    tick_ff;

   // Walk and search state.
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [IDX_W-1:0]     ptr_ff, ptr_in;
   logic                 srch_done_ff, srch_done_in;
   logic                 found_ff, found_in;
   logic                 ok_ff, ok_in;
   logic                 pend_ff, pend_in;
   logic [HANDLER_W-1:0] pend_h_ff, pend_h_in;
   logic [OUT_CNT_W-1:0] out_cnt_ff, out_cnt_in;

   // Response register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic                 rsp_fired_ff, rsp_fired_in;
   logic [HANDLER_W-1:0] rsp_handler_ff, rsp_handler_in;
   logic                 rsp_last_ff, rsp_last_in;

   // RAM ports and slot fields.
   logic                  wr_en;
   logic [WORD_W-1:0]     wr_word;
   logic [IDX_W-1:0]      rd_addr;
   logic [WORD_W-1:0]     rd_word;
   logic [HANDLER_W-1:0]  r_handler;
   logic [COUNT_BITS-1:0] r_rem;
   logic [COUNT_BITS-1:0] r_reload;
   logic                  r_once;

   // Divider connection.
   logic [TICK_W-1:0]     div_divisor;
   logic                  div_done;
   logic [INTERVAL_W-1:0] div_quo;
   logic [COUNT_BITS-1:0] add_cnt;

   // Per-slot decisions.
   logic cur_valid;
   logic last_ptr;
   logic match;
   logic fire_cand;
   logic hold;
   logic step;
   logic push_mid;
   logic out_free;
   logic is_scan;

   mstt_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ptr_ff),
      .wr_data (wr_word),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // A tick length of zero divides as one.
   assign div_divisor = (tick_ff == '0) ? TICK_W'(1) : tick_ff;

   mstt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.load),
      .dividend (req_interval_ms),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Counts too wide for the slot saturate.
   assign add_cnt = (div_quo > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
                                          : div_quo[COUNT_BITS-1:0];

   // Fields of the slot word on the read port.
   assign r_handler = rd_word[HANDLER_W-1:0];
   assign r_rem     = rd_word[HANDLER_W +: COUNT_BITS];
   assign r_reload  = rd_word[HANDLER_W + COUNT_BITS +: COUNT_BITS];
   assign r_once    = rd_word[WORD_W-1];

   // Decisions for the slot at the pointer. A free slot matches handler zero.
   always_comb begin
      is_scan   = (kind_ff == KIND_SCAN);
      cur_valid = valid_ff[ptr_ff];
      last_ptr  = (ptr_ff == IDX_W'(SLOTS - 1));
      match     = cur_valid ? (r_handler == handler_ff) : (handler_ff == '0);
      out_free  = !rsp_valid_ff || !rsp_stall;
      fire_cand = is_scan && cur_valid && (r_rem == '0) &&
                  (out_cnt_ff < OUT_CNT_W'(MAX_OUT));
      hold      = fire_cand && pend_ff && !out_free;
      step      = cmd.walk && !hold;
      push_mid  = step && fire_cand && pend_ff;
   end

   // Walk reads the next slot when stepping, else the current one; else slot 0.
   always_comb begin
      if (cmd.walk) begin
         rd_addr = (step && !last_ptr) ? (ptr_ff + IDX_W'(1)) : ptr_ff;
      end else begin
         rd_addr = '0;
      end
   end

   // Slot write-back.
   always_comb begin
      wr_en   = 1'b0;
      wr_word = rd_word;
      if (cmd.add_commit) begin
         wr_en   = found_ff;
         wr_word = {once_ff, add_cnt, add_cnt, handler_ff};
      end else if (step && (kind_ff == KIND_TICK) && cur_valid && (r_rem != '0)) begin
         wr_en   = 1'b1;
         wr_word = {r_once, r_reload, r_rem - COUNT_BITS'(1), r_handler};
      end else if (step && fire_cand && !r_once) begin
         wr_en   = 1'b1;
         wr_word = {r_once, r_reload, r_reload, r_handler};
      end
   end

   // Occupied bits, pointer, search and scan bookkeeping.
   always_comb begin
      valid_in     = valid_ff;
      ptr_in       = ptr_ff;
      srch_done_in = srch_done_ff;
      found_in     = found_ff;
      ok_in        = ok_ff;
      pend_in      = pend_ff;
      pend_h_in    = pend_h_ff;
      out_cnt_in   = out_cnt_ff;
      if (cmd.load) begin
         ptr_in       = '0;
         srch_done_in = 1'b0;
         found_in     = 1'b0;
         pend_in      = 1'b0;
         out_cnt_in   = '0;
         ok_in        = (req_kind == KIND_TICK) || (req_kind == KIND_SCAN) ||
                        (req_kind == KIND_CLEAN);
      end
      if (cmd.clear_all) begin
         valid_in = '0;
      end
      // First free slot search for an add.
      if (cmd.search && !srch_done_ff) begin
         if (!cur_valid) begin
            found_in     = 1'b1;
            srch_done_in = 1'b1;
         end else if (last_ptr) begin
            srch_done_in = 1'b1;
         end else begin
            ptr_in = ptr_ff + IDX_W'(1);
         end
      end
      // A handler of zero never marks a slot as occupied.
      if (cmd.add_commit) begin
         ok_in = found_ff;
         if (found_ff && (handler_ff != '0)) begin
            valid_in[ptr_ff] = 1'b1;
         end
      end
      // Slot walk for check, delete, tick and scan.
      if (step) begin
         if (!last_ptr) begin
            ptr_in = ptr_ff + IDX_W'(1);
         end
         if (((kind_ff == KIND_CHECK) || (kind_ff == KIND_DELETE)) && match) begin
            ok_in = 1'b1;
         end
         if ((kind_ff == KIND_DELETE) && cur_valid && match) begin
            valid_in[ptr_ff] = 1'b0;
         end
         if (fire_cand) begin
            pend_in    = 1'b1;
            pend_h_in  = r_handler;
            out_cnt_in = out_cnt_ff + OUT_CNT_W'(1);
            if (r_once) begin
               valid_in[ptr_ff] = 1'b0;
            end
         end
      end
   end

   // Response register: an earlier expired slot leaves when a later one
   // fires; the closing response carries the last mark.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_ok_in      = rsp_ok_ff;
      rsp_fired_in   = rsp_fired_ff;
      rsp_handler_in = rsp_handler_ff;
      rsp_last_in    = rsp_last_ff;
      if (push_mid) begin
         rsp_valid_in   = 1'b1;
         rsp_ok_in      = 1'b1;
         rsp_fired_in   = 1'b1;
         rsp_handler_in = pend_h_ff;
         rsp_last_in    = 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b1;
         if (is_scan) begin
            rsp_ok_in      = 1'b1;
            rsp_fired_in   = pend_ff;
            rsp_handler_in = pend_ff ? pend_h_ff : '0;
         end else begin
            rsp_ok_in      = ok_ff;
            rsp_fired_in   = 1'b0;
            rsp_handler_in = '0;
         end
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= TICK_RESET;
         valid_ff     <= '0;
         ptr_ff       <= '0;
         srch_done_ff <= 1'b0;
         found_ff     <= 1'b0;
         ok_ff        <= 1'b0;
         pend_ff      <= 1'b0;
         out_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tick_ff <= csr_wr_data;
         end
         valid_ff     <= valid_in;
         ptr_ff       <= ptr_in;
         srch_done_ff <= srch_done_in;
         found_ff     <= found_in;
         ok_ff        <= ok_in;
         pend_ff      <= pend_in;
         out_cnt_ff   <= out_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load) begin
         kind_ff    <= req_kind;
         handler_ff <= req_handler_id;
         once_ff    <= req_once_mode;
      end
      pend_h_ff      <= pend_h_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_fired_ff   <= rsp_fired_in;
      rsp_handler_ff <= rsp_handler_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Status to the controller.
   always_comb begin
      status.div_done    = div_done;
      status.search_done = srch_done_ff;
      status.walk_done   = step && last_ptr;
      status.out_free    = out_free;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_fired         = rsp_fired_ff;
   assign rsp_fired_handler = rsp_handler_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

@@ src/multi_slot_timer_table.sv @@
// Check, delete, tick and scan walk the slot RAM one slot per cycle unless a stalled
// result holds the walk. Add runs the divider beside the free slot search and writes
// the slot once both are done. Clean and unused kinds go straight to the response.
// A stalled result delays any kind; one transaction runs at a time.
// Synchronous reset frees every slot at once through the occupied bits; tick_ms is 1.
// ============================================================================
// multi_slot_timer_table: table of one-shot and periodic software timers
// Top level joining the operation sequencer and the slot table datapath.
// ============================================================================
module multi_slot_timer_table
   import mstt_pkg::*;
#(
   parameter int SLOTS      = 16,
   parameter int COUNT_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [HANDLER_W-1:0]  req_handler_id,
   input  logic [INTERVAL_W-1:0] req_interval_ms,
   input  logic                  req_once_mode,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_ok,
   output logic                  rsp_fired,
   output logic [HANDLER_W-1:0]  rsp_fired_handler,
   output logic                  rsp_last,
   input  logic                  csr_wr_en,
   input  logic [TICK_W-1:0]     csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   mstt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .status    (status),
      .cmd       (cmd)
   );

   mstt_dp #(
      .SLOTS      (SLOTS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_kind),
      .req_handler_id    (req_handler_id),
      .req_interval_ms   (req_interval_ms),
      .req_once_mode     (req_once_mode),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_ok            (rsp_ok),
      .rsp_fired         (rsp_fired),
      .rsp_fired_handler (rsp_fired_handler),
      .rsp_last          (rsp_last)
   );

endmodule

@@ src/mstt_checker.sv @@
// ============================================================================
// mstt_checker: port-level checks of the timer slot table
// Watches the response channel for consistent result fields over time.
// ============================================================================
module mstt_checker
   import mstt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_ok,
   input logic                  rsp_fired,
   input logic [HANDLER_W-1:0]  rsp_fired_handler,
   input logic                  rsp_last
);

   // No result is offered right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fired_handler) &&
      $stable(rsp_last) && $stable(rsp_fired) && $stable(rsp_ok))
      else $error("stalled response changed");

   // An expired timer always carries a live handler and a set ok flag.
   a_fired_live: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired |-> rsp_ok && (rsp_fired_handler != '0))
      else $error("fired result without a live handler");

   // Only scan results come without the last mark, and those always fire.
   a_not_fired_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired |-> rsp_last && (rsp_fired_handler == '0))
      else $error("non-fired result not closing its transaction");

   // A request is not taken while a scan is still delivering its results.
   a_no_accept_mid_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("request accepted during a scan");

endmodule

bind multi_slot_timer_table mstt_checker u_checker (.*);

@@ sim/multi_slot_timer_table_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// multi_slot_timer_table_tb: self-checking bench for the timer slot table
// Drives add, check, delete, tick, scan, clean and the spare kinds through the
// request channel and keeps its own copy of the slot table to predict every
// response. Responses are compared field by field in order. Both channels
// idle and stall at random, and the tick length is changed between phases.
// ============================================================================
module multi_slot_timer_table_tb;
   import mstt_pkg::*;

   localparam int NUM_SLOTS      = 16;
   localparam int NUM_COUNT_BITS = 32;
   localparam int CLK_HALF       = 6;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 40;

   // Kinds that the block does not implement.
   localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

   typedef struct packed {
      logic                 ok;
      logic                 fired;
      logic [HANDLER_W-1:0] handler;
      logic                 last;
   } timer_reply_t;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [KIND_W-1:0]     req_kind;
   logic [HANDLER_W-1:0]  req_handler_id;
   logic [INTERVAL_W-1:0] req_interval_ms;
   logic                  req_once_mode;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_ok;
   logic                  rsp_fired;
   logic [HANDLER_W-1:0]  rsp_fired_handler;
   logic                  rsp_last;
   logic                  csr_wr_en;
   logic [TICK_W-1:0]     csr_wr_data;

   // Shadow copy of the slot table and the tick length register.
   logic [TICK_W-1:0]         tm_tick_ms;
   logic [HANDLER_W-1:0]      tm_handler   [NUM_SLOTS];
   logic [NUM_COUNT_BITS-1:0] tm_remaining [NUM_SLOTS];
   logic [NUM_COUNT_BITS-1:0] tm_reload    [NUM_SLOTS];
   logic                      tm_once      [NUM_SLOTS];

   timer_reply_t pending_replies[$];

   bit quiet;
   int fail_count;
   int requests_sent;
   int replies_checked;
   int expirations_seen;
   int tick_settings;

   multi_slot_timer_table #(
      .SLOTS      (NUM_SLOTS),
      .COUNT_BITS (NUM_COUNT_BITS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_handler_id    (req_handler_id),
      .req_interval_ms   (req_interval_ms),
      .req_once_mode     (req_once_mode),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ok            (rsp_ok),
      .rsp_fired         (rsp_fired),
      .rsp_fired_handler (rsp_fired_handler),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   function automatic timer_reply_t reply_of(input logic ok, input logic fired,
                                             input logic [HANDLER_W-1:0] hid,
                                             input logic last);
      timer_reply_t r;
      r.ok      = ok;
      r.fired   = fired;
      r.handler = hid;
      r.last    = last;
      return r;
   endfunction

   // Applies one accepted request to the shadow table and queues the responses
   // that it must produce, in order.
   function automatic void timer_table_apply(input logic [KIND_W-1:0] kind,
                                             input logic [HANDLER_W-1:0] hid,
                                             input logic [INTERVAL_W-1:0] ivl,
                                             input logic once);
      logic                      ok;
      logic                      found;
      logic [INTERVAL_W-1:0]     divisor;
      logic [NUM_COUNT_BITS-1:0] count;
      logic [HANDLER_W-1:0]      hits [MAX_OUT];
      int                        n;
      ok    = 1'b0;
      found = 1'b0;
      n     = 0;
      case (kind)
         KIND_ADD: begin
            // A zero tick length divides by one. The count cannot exceed
            // 32 bits here, so it never saturates.
            divisor = (tm_tick_ms == '0) ? INTERVAL_W'(1) : INTERVAL_W'(tm_tick_ms);
            count   = ivl / divisor;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (!found && tm_handler[i] == '0) begin
                  tm_remaining[i] = count;
                  tm_reload[i]    = count;
                  tm_handler[i]   = hid;
                  tm_once[i]      = once;
                  found           = 1'b1;
               end
            end
            ok = found;
         end
         KIND_CHECK: begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (tm_handler[i] == hid) ok = 1'b1;
         end
         KIND_DELETE: begin
            // Every matching slot is freed; the mode bit stays.
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (tm_handler[i] == hid) begin
                  tm_remaining[i] = '0;
                  tm_reload[i]    = '0;
                  tm_handler[i]   = '0;
                  ok              = 1'b1;
               end
            end
         end
         KIND_TICK: begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (tm_handler[i] != '0 && tm_remaining[i] != '0)
                  tm_remaining[i] = tm_remaining[i] - 1'b1;
            ok = 1'b1;
         end
         KIND_SCAN: begin
            // Expired slots in slot order; one-shot slots are freed, periodic
            // slots reload.
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (n < MAX_OUT && tm_handler[i] != '0 && tm_remaining[i] == '0) begin
                  hits[n] = tm_handler[i];
                  if (tm_once[i]) begin
                     tm_reload[i]  = '0;
                     tm_handler[i] = '0;
                  end else begin
                     tm_remaining[i] = tm_reload[i];
                  end
                  n++;
               end
            end
         end
         KIND_CLEAN: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               tm_handler[i]   = '0;
               tm_remaining[i] = '0;
               tm_reload[i]    = '0;
            end
            ok = 1'b1;
         end
         default: ok = 1'b0;
      endcase

      if (kind != KIND_SCAN) begin
         pending_replies.push_back(reply_of(ok, 1'b0, '0, 1'b1));
      end else if (n == 0) begin
         pending_replies.push_back(reply_of(1'b1, 1'b0, '0, 1'b1));
      end else begin
         for (int k = 0; k < n; k++)
            pending_replies.push_back(reply_of(1'b1, 1'b1, hits[k], k == n - 1));
         expirations_seen += n;
      end
   endfunction

   // Sender idle time: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   // Presents one request, holds it until accepted, then predicts it.
   task automatic send_op(input logic [KIND_W-1:0] kind, input logic [HANDLER_W-1:0] hid,
                          input logic [INTERVAL_W-1:0] ivl, input logic once);
      int gap;
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_handler_id  <= hid;
      req_interval_ms <= ivl;
      req_once_mode   <= once;
      do @(posedge clock); while (req_stall);
      timer_table_apply(kind, hid, ivl, once);
      requests_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every predicted response has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_tick(input logic [TICK_W-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      tm_tick_ms  = value;
      tick_settings++;
   endtask

   // Lookups and scans on the empty table, and the spare kinds.
   task automatic test_empty_table();
      send_op(KIND_CHECK, 16'hFFFF, '0, 1'b0);
      send_op(KIND_SCAN, 16'h5A5A, 32'h1234_5678, 1'b1);
      send_op(KIND_SPARE_A, 16'h0001, 32'hFFFF_FFFF, 1'b1);
      send_op(KIND_SPARE_B, 16'hFFFF, 32'h8000_0001, 1'b0);
   endtask

   // Handler zero marks a free slot: add leaves the slot free, and check and
   // delete match free slots.
   task automatic test_handler_zero();
      send_op(KIND_ADD, 16'h0000, 32'd5, 1'b1);
      send_op(KIND_CHECK, 16'h0000, '0, 1'b0);
      send_op(KIND_DELETE, 16'h0000, '0, 1'b0);
   endtask

   // Fills all slots with duplicate handlers, overflows the table, then lets
   // every slot expire in one scan.
   task automatic test_full_table();
      send_op(KIND_CLEAN, '0, '0, 1'b0);
      for (int i = 0; i < NUM_SLOTS; i++)
         send_op(KIND_ADD, HANDLER_W'((i % 4) + 1), '0, i[0]);
      send_op(KIND_ADD, 16'h0009, 32'd7, 1'b0);
      send_op(KIND_CHECK, 16'h0000, '0, 1'b0);
      send_op(KIND_SCAN, '0, '0, 1'b0);
      send_op(KIND_CLEAN, '0, '0, 1'b0);
   endtask

   // Interval division at a zero tick length, the widest interval and the
   // largest tick length.
   task automatic test_tick_length();
      write_tick('0);
      send_op(KIND_ADD, 16'h0001, 32'd2, 1'b1);
      send_op(KIND_TICK, '0, '0, 1'b0);
      send_op(KIND_TICK, '0, '0, 1'b0);
      send_op(KIND_SCAN, '0, '0, 1'b0);
      write_tick(10'd1000);
      send_op(KIND_ADD, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      send_op(KIND_DELETE, 16'hFFFF, '0, 1'b0);
      write_tick(10'd1023);
      send_op(KIND_ADD, 16'h8000, 32'd1023, 1'b0);
      send_op(KIND_TICK, '0, '0, 1'b0);
      send_op(KIND_SCAN, '0, '0, 1'b0);
   endtask

   // Random operation mix on a small pool of handlers so that lookups hit and
   // timers expire; some noise with wide fields. The first calm_items go
   // without any idling, and the sender drains the block at pause_at.
   task automatic test_random_traffic(input int count, input int calm_items,
                                      input int pause_at);
      int                    r;
      int                    span;
      logic [KIND_W-1:0]     kind;
      logic [HANDLER_W-1:0]  hid;
      logic [INTERVAL_W-1:0] ivl;
      logic                  once;
      for (int k = 0; k < count; k++) begin
         quiet = (k < calm_items);
         if (k == pause_at) wait_idle();
         r = $urandom_range(0, 99);
         if (r < 28)      kind = KIND_ADD;
         else if (r < 38) kind = KIND_CHECK;
         else if (r < 48) kind = KIND_DELETE;
         else if (r < 72) kind = KIND_TICK;
         else if (r < 94) kind = KIND_SCAN;
         else if (r < 97) kind = KIND_CLEAN;
         else             kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;

         r = $urandom_range(0, 99);
         if (r < 80)      hid = HANDLER_W'($urandom_range(1, 6));
         else if (r < 96) hid = HANDLER_W'($urandom);
         else             hid = '0;

         span = (tm_tick_ms == '0) ? 1 : int'(tm_tick_ms);
         r = $urandom_range(0, 99);
         if (r < 85)
            ivl = INTERVAL_W'(span * $urandom_range(0, 5) + $urandom_range(0, span - 1));
         else if (r < 95)
            ivl = INTERVAL_W'($urandom);
         else
            ivl = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;

         once = 1'($urandom_range(0, 1));
         send_op(kind, hid, ivl, once);
      end
      quiet = 1'b0;
   endtask

   // Receiver stall pattern: short bursts, occasional long stalls and calm
   // stretches with no stall at all.
   initial begin : stall_gen
      int hold;
      int r;
      hold      = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (quiet) begin
            rsp_stall <= 1'b0;
            hold = 0;
         end else if (hold > 0) begin
            hold--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               rsp_stall <= 1'b0;
               hold = $urandom_range(0, 3);
            end else if (r < 85) begin
               rsp_stall <= 1'b1;
               hold = $urandom_range(0, 2);
            end else if (r < 93) begin
               rsp_stall <= 1'b1;
               hold = $urandom_range(8, 35);
            end else begin
               rsp_stall <= 1'b0;
               hold = $urandom_range(40, 150);
            end
         end
      end
   end

   // Compares each accepted response with the oldest prediction.
   always @(posedge clock) begin : reply_check
      timer_reply_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            $error("unexpected response: ok=%0d fired=%0d fired_handler=%0h last=%0d",
                   rsp_ok, rsp_fired, rsp_fired_handler, rsp_last);
            fail_count++;
         end else begin
            want = pending_replies.pop_front();
            replies_checked++;
            if (rsp_ok !== want.ok) begin
               $error("ok: expected %0d, actual %0d", want.ok, rsp_ok);
               fail_count++;
            end
            if (rsp_fired !== want.fired) begin
               $error("fired: expected %0d, actual %0d", want.fired, rsp_fired);
               fail_count++;
            end
            if (rsp_fired_handler !== want.handler) begin
               $error("fired_handler: expected %0h, actual %0h", want.handler,
                      rsp_fired_handler);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // Ends a hung run: counts cycles in which neither channel moves a transaction.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d responses pending.",
                     WATCHDOG_LIMIT, pending_replies.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Test sequence.
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_kind        = KIND_ADD;
      req_handler_id  = '0;
      req_interval_ms = '0;
      req_once_mode   = 1'b0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      quiet           = 1'b0;
      tm_tick_ms      = TICK_RESET;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         tm_handler[i]   = '0;
         tm_remaining[i] = '0;
         tm_reload[i]    = '0;
         tm_once[i]      = 1'b0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_handler_zero();
      test_full_table();
      test_tick_length();

      write_tick(10'd1);
      test_random_traffic(95, 0, 50);
      write_tick(10'($urandom_range(2, 999)));
      test_random_traffic(95, 30, -1);
      write_tick('0);
      test_random_traffic(95, 0, -1);
      write_tick(10'd1023);
      test_random_traffic(95, 0, 70);

      // Drain and give the block time to show any stray response.
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d requests over %0d tick lengths; checked %0d responses", requests_sent,
               tick_settings, replies_checked);
      $display("including %0d expired timers; %0d mismatches.", expirations_seen, fail_count);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

@@ multi_slot_timer_table.f @@
src/mstt_pkg.sv
src/mstt_ram.sv
src/mstt_div.sv
src/mstt_ctrl.sv
src/mstt_dp.sv
src/multi_slot_timer_table.sv
src/mstt_checker.sv
sim/multi_slot_timer_table_tb.sv
